// File: hw/rtl/pse_pkg.sv
package pse_pkg;

   localparam int SYMBOL_WIDTH = 8;
   localparam int VALUE_WIDTH  = 32;
   localparam int STATUS_WIDTH = 3;

   typedef logic [SYMBOL_WIDTH-1:0] symbol_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;

   localparam status_type STATUS_OK        = 3'd0;
   localparam status_type STATUS_OVERFLOW  = 3'd1;
   localparam status_type STATUS_UNDERFLOW = 3'd2;
   localparam status_type STATUS_INVALID   = 3'd3;
   localparam status_type STATUS_DIVZERO   = 3'd4;
   localparam status_type STATUS_EMPTY     = 3'd5;

   localparam symbol_type SYM_PLUS    = 8'h2B;
   localparam symbol_type SYM_MINUS   = 8'h2D;
   localparam symbol_type SYM_STAR    = 8'h2A;
   localparam symbol_type SYM_SLASH   = 8'h2F;
   localparam symbol_type SYM_PERCENT = 8'h25;
   localparam symbol_type SYM_CARET   = 8'h5E;
   localparam symbol_type SYM_DIGIT_0 = 8'h30;
   localparam symbol_type SYM_DIGIT_9 = 8'h39;
   localparam symbol_type SYM_UPPER_A = 8'h41;
   localparam symbol_type SYM_UPPER_Z = 8'h5A;
   localparam symbol_type SYM_LOWER_A = 8'h61;
   localparam symbol_type SYM_LOWER_Z = 8'h7A;

   typedef enum logic [3:0] {
      KIND_LETTER,
      KIND_DIGIT,
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV,
      KIND_MOD,
      KIND_XOR,
      KIND_INVALID
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_EXEC,
      S_ITER,
      S_PUSH,
      S_TOP,
      S_RESP
   } state_type;

   typedef struct packed {
      logic ready;
      logic load_operands;
      logic exec_alu;
      logic start_md;
      logic capture_md;
      logic push;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic     req_valid;
      kind_type kind;
      logic     last;
      logic     b_zero;
      logic     md_done;
      logic     rsp_busy;
   } stat_type;

   function automatic kind_type decode_symbol(symbol_type sym);
      kind_type k;
      if (sym inside {[SYM_UPPER_A:SYM_UPPER_Z], [SYM_LOWER_A:SYM_LOWER_Z]}) begin
         k = KIND_LETTER;
      end else if (sym inside {[SYM_DIGIT_0:SYM_DIGIT_9]}) begin
         k = KIND_DIGIT;
      end else begin
         unique case (sym)
            SYM_PLUS:    k = KIND_ADD;
            SYM_MINUS:   k = KIND_SUB;
            SYM_STAR:    k = KIND_MUL;
            SYM_SLASH:   k = KIND_DIV;
            SYM_PERCENT: k = KIND_MOD;
            SYM_CARET:   k = KIND_XOR;
            default:     k = KIND_INVALID;
         endcase
      end
      return k;
   endfunction

endpackage

// File: hw/rtl/pse_req_if.sv
interface pse_req_if;
   logic                               valid;
   logic                               ready;
   pse_pkg::symbol_type                symbol;
   logic signed [pse_pkg::VALUE_WIDTH-1:0] operand_value;
   logic                               last;

   modport source (output valid, symbol, operand_value, last, input ready);
   modport sink (input valid, symbol, operand_value, last, output ready);
endinterface

// File: hw/rtl/pse_rsp_if.sv
interface pse_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pse_pkg::VALUE_WIDTH-1:0] result_value;
   pse_pkg::status_type                    status;

   modport source (output valid, result_value, status, input ready);
   modport sink (input valid, result_value, status, output ready);
endinterface

// File: hw/rtl/pse_muldiv.sv
module pse_muldiv #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  pse_pkg::kind_type      kind,
   input  logic [DATA_WIDTH-1:0]  a,
   input  logic [DATA_WIDTH-1:0]  b,
   output logic                   done,
   output logic [DATA_WIDTH-1:0]  result
);

   localparam int CW = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   pse_pkg::kind_type     kind_ff, kind_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] x_ff, x_in;
   logic [DATA_WIDTH-1:0] y_ff, y_in;
   logic                  neg_q_ff, neg_q_in;
   logic                  neg_r_ff, neg_r_in;

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;
   logic [DATA_WIDTH-1:0] mag_a;
   logic [DATA_WIDTH-1:0] mag_b;

   assign mag_a   = a[DATA_WIDTH-1] ? '0 - a : a;
   assign mag_b   = b[DATA_WIDTH-1] ? '0 - b : b;
   // restoring division: one quotient bit per cycle
   assign shifted = {acc_ff, x_ff[DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, y_ff};
   assign fits    = (shifted >= {1'b0, y_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CW'(DATA_WIDTH);
         kind_in  = kind;
         acc_in   = '0;
         neg_q_in = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
         neg_r_in = a[DATA_WIDTH-1];
         if (kind == pse_pkg::KIND_MUL) begin
            x_in = a;
            y_in = b;
         end else begin
            x_in = mag_a;
            y_in = mag_b;
         end
      end else if (busy_ff) begin
         if (kind_ff == pse_pkg::KIND_MUL) begin
            if (y_ff[0]) begin
               acc_in = acc_ff + x_ff;
            end
            x_in = {x_ff[DATA_WIDTH-2:0], 1'b0};
            y_in = {1'b0, y_ff[DATA_WIDTH-1:1]};
         end else begin
            acc_in = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            x_in   = {x_ff[DATA_WIDTH-2:0], fits};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      kind_ff  <= kind_in;
      acc_ff   <= acc_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   always_comb begin
      case (kind_ff)
         pse_pkg::KIND_MUL: result = acc_ff;
         pse_pkg::KIND_DIV: result = neg_q_ff ? '0 - x_ff : x_ff;
         default:           result = neg_r_ff ? '0 - acc_ff : acc_ff;
      endcase
   end

   assign done = done_ff;

endmodule

// File: hw/rtl/pse_datapath.sv
module pse_datapath #(
   parameter int STACK_DEPTH = 8,
   parameter int DATA_WIDTH  = 32
) (
   input  logic              clock,
   input  logic              reset,
   pse_req_if.sink           req_chan,
   pse_rsp_if.source         rsp_chan,
   input  pse_pkg::cmd_type  cmd,
   output pse_pkg::stat_type stat
);

   localparam int CW      = $clog2(STACK_DEPTH + 1);
   localparam int IW      = $clog2(STACK_DEPTH);
   localparam int VALUE_W = pse_pkg::VALUE_WIDTH;

   typedef logic [DATA_WIDTH-1:0] word_type;

   word_type stack_mem [STACK_DEPTH];

   pse_pkg::kind_type   kind_ff, kind_in;
   logic                last_ff, last_in;
   word_type            val_ff, val_in;
   word_type            a_ff, a_in;
   word_type            b_ff, b_in;
   word_type            res_ff, res_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   pse_pkg::status_type err_ff, err_in;
   word_type            rd_a_ff;
   word_type            rd_b_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   pse_pkg::status_type rsp_status_ff, rsp_status_in;

   logic                accept;
   logic                is_oper;
   logic [IW-1:0]       rd_a_idx;
   logic [IW-1:0]       rd_b_idx;
   logic [IW-1:0]       wr_idx;
   logic                mem_we;
   logic                note_en;
   pse_pkg::status_type note_code;
   logic                md_done;
   word_type            md_result;

   assign accept         = req_chan.valid && cmd.ready;
   assign req_chan.ready = cmd.ready;
   assign is_oper        = (kind_ff != pse_pkg::KIND_LETTER) && (kind_ff != pse_pkg::KIND_DIGIT);

   // top and next-to-top, read every cycle
   assign rd_a_idx = (cnt_ff == '0) ? '0 : IW'(cnt_ff - 1'b1);
   assign rd_b_idx = (cnt_ff < CW'(2)) ? '0 : IW'(cnt_ff - CW'(2));
   assign wr_idx   = IW'(cnt_ff);

   pse_muldiv #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_md),
      .kind   (kind_ff),
      .a      (a_ff),
      .b      (b_ff),
      .done   (md_done),
      .result (md_result)
   );

   always_comb begin
      kind_in       = kind_ff;
      last_in       = last_ff;
      val_in        = val_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      res_in        = res_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      note_en       = 1'b0;
      note_code     = pse_pkg::STATUS_OK;

      if (accept) begin
         kind_in = pse_pkg::decode_symbol(req_chan.symbol);
         last_in = req_chan.last;
         if (kind_in == pse_pkg::KIND_LETTER) begin
            val_in = DATA_WIDTH'(req_chan.operand_value);
         end else begin
            val_in = DATA_WIDTH'(req_chan.symbol - pse_pkg::SYM_DIGIT_0);
         end
      end

      if (cmd.load_operands && is_oper) begin
         if (cnt_ff >= CW'(2)) begin
            b_in   = rd_a_ff;
            a_in   = rd_b_ff;
            cnt_in = cnt_ff - CW'(2);
         end else begin
            b_in      = (cnt_ff == CW'(1)) ? rd_a_ff : '0;
            a_in      = '0;
            cnt_in    = '0;
            note_en   = 1'b1;
            note_code = pse_pkg::STATUS_UNDERFLOW;
         end
      end

      if (cmd.exec_alu) begin
         case (kind_ff)
            pse_pkg::KIND_LETTER,
            pse_pkg::KIND_DIGIT: res_in = val_ff;
            pse_pkg::KIND_ADD:   res_in = a_ff + b_ff;
            pse_pkg::KIND_SUB:   res_in = a_ff - b_ff;
            pse_pkg::KIND_XOR:   res_in = a_ff ^ b_ff;
            default:             res_in = '0;
         endcase
         if (kind_ff inside {pse_pkg::KIND_DIV, pse_pkg::KIND_MOD}) begin
            note_en   = 1'b1;
            note_code = pse_pkg::STATUS_DIVZERO;
         end
      end

      if (cmd.capture_md) begin
         res_in = md_result;
      end

      if (cmd.push) begin
         if (kind_ff == pse_pkg::KIND_INVALID) begin
            note_en   = 1'b1;
            note_code = pse_pkg::STATUS_INVALID;
         end else if (cnt_ff == CW'(STACK_DEPTH)) begin
            note_en   = 1'b1;
            note_code = pse_pkg::STATUS_OVERFLOW;
         end else begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
      end

      // only the first error since the last result is kept
      err_in = (note_en && err_ff == pse_pkg::STATUS_OK) ? note_code : err_ff;

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         if (cnt_ff == '0) begin
            rsp_value_in  = '0;
            rsp_status_in = (err_ff != pse_pkg::STATUS_OK) ? err_ff : pse_pkg::STATUS_EMPTY;
         end else begin
            rsp_value_in  = VALUE_W'(signed'(rd_a_ff));
            rsp_status_in = err_ff;
         end
         cnt_in = '0;
         err_in = pse_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         err_ff       <= pse_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      last_ff       <= last_in;
      val_ff        <= val_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      res_ff        <= res_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_idx] <= res_ff;
      end
      rd_a_ff <= stack_mem[rd_a_idx];
      rd_b_ff <= stack_mem[rd_b_idx];
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.status       = rsp_status_ff;

   assign stat.req_valid = req_chan.valid;
   assign stat.kind      = kind_ff;
   assign stat.last      = last_ff;
   assign stat.b_zero    = (b_ff == '0);
   assign stat.md_done   = md_done;
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_chan.ready;

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !stat.rsp_busy)
      else $error("result loaded while previous item still pending");

   a_clear_after_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (cnt_ff == '0) && (err_ff == pse_pkg::STATUS_OK))
      else $error("stack or error not cleared after result");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.push && kind_ff != pse_pkg::KIND_INVALID && cnt_ff < CW'(STACK_DEPTH)
      |=> cnt_ff == CW'($past(cnt_ff) + 1'b1))
      else $error("push with room did not grow the stack");

   a_capture_on_done: assert property (@(posedge clock) disable iff (reset)
      cmd.capture_md |-> md_done)
      else $error("mul/div result taken before unit finished");

endmodule

// File: hw/rtl/pse_ctrl.sv
module pse_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  pse_pkg::stat_type stat,
   output pse_pkg::cmd_type  cmd
);

   pse_pkg::state_type state_ff, state_in;
   logic               uses_md;

   // divide or modulo by zero skips the iterative unit
   assign uses_md = (stat.kind == pse_pkg::KIND_MUL)
                 || ((stat.kind inside {pse_pkg::KIND_DIV, pse_pkg::KIND_MOD}) && !stat.b_zero);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pse_pkg::S_IDLE: if (stat.req_valid) state_in = pse_pkg::S_POP;
         pse_pkg::S_POP:  state_in = pse_pkg::S_EXEC;
         pse_pkg::S_EXEC: state_in = uses_md ? pse_pkg::S_ITER : pse_pkg::S_PUSH;
         pse_pkg::S_ITER: if (stat.md_done) state_in = pse_pkg::S_PUSH;
         pse_pkg::S_PUSH: state_in = stat.last ? pse_pkg::S_TOP : pse_pkg::S_IDLE;
         pse_pkg::S_TOP:  state_in = pse_pkg::S_RESP;
         pse_pkg::S_RESP: if (!stat.rsp_busy) state_in = pse_pkg::S_IDLE;
         default:         state_in = pse_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         pse_pkg::S_IDLE: cmd.ready         = 1'b1;
         pse_pkg::S_POP:  cmd.load_operands = 1'b1;
         pse_pkg::S_EXEC: begin
            cmd.start_md = uses_md;
            cmd.exec_alu = !uses_md;
         end
         pse_pkg::S_ITER: cmd.capture_md    = stat.md_done;
         pse_pkg::S_PUSH: cmd.push          = 1'b1;
         pse_pkg::S_TOP:  cmd               = '0;
         pse_pkg::S_RESP: cmd.load_rsp      = !stat.rsp_busy;
         default:         cmd               = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pse_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/postfix_stack_evaluator_core.sv
// Postfix evaluator: one symbol per item on req_chan. Letters push operand_value, digits
// push 0..9, + - * / % ^ pop two values and push the result; an item with last set
// produces one result item on rsp_chan (top of stack and first error, then the stack
// clears). Items are handled one at a time: a push, +, -, ^, an unknown symbol or a divide
// by zero steps from accept through the pop, execute and push states to the next accept,
// and any other *, / or % also waits in the iterate state for the shared shift-add /
// restoring divide unit that retires one bit per cycle. An item with last set adds a
// top-of-stack state to read the top of stack from the registered-read stack memory, plus
// any wait while the previous result is still held in the output register.
module postfix_stack_evaluator_core #(
   parameter int STACK_DEPTH = 8,
   parameter int DATA_WIDTH  = 32
) (
   input logic       clock,
   input logic       reset,
   pse_req_if.sink   req_chan,
   pse_rsp_if.source rsp_chan
);

   pse_pkg::cmd_type  cmd;
   pse_pkg::stat_type stat;

   pse_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   pse_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule
